// File: src/order_lifecycle_tracker_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the order lifecycle tracker
// Short forms for clocked implication checks with synchronous reset masking.
// ----------------------------------------------------------------------------
`ifndef ORDER_LIFECYCLE_TRACKER_TOP_ASSERT_SVH
`define ORDER_LIFECYCLE_TRACKER_TOP_ASSERT_SVH

// Same-cycle implication.
`define OLT_ASSERT_NOW(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define OLT_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/olt_pkg.sv
// ----------------------------------------------------------------------------
// olt_pkg
// Shared types, codes and widths of the order lifecycle tracker.
// ----------------------------------------------------------------------------
package olt_pkg;

  localparam int MAX_ORDERS = 256;
  localparam int QTY_BITS   = 32;
  localparam int PRICE_BITS = 32;
  localparam int ID_BITS    = $clog2(MAX_ORDERS);
  localparam int CNT_BITS   = ID_BITS + 1;
  localparam int QDEPTH     = 2;

  typedef enum logic [2:0] {
    CMD_NEW    = 3'd0,
    CMD_CHANGE = 3'd1,
    CMD_ACK    = 3'd2,
    CMD_FILL   = 3'd3,
    CMD_DISC   = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    ST_SENDING   = 3'd0,
    ST_ACKED     = 3'd1,
    ST_PARTIAL   = 3'd2,
    ST_FILLED    = 3'd3,
    ST_CANCELLED = 3'd4,
    ST_FAILED    = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    OP_UNKNOWN   = 3'd0,
    OP_NEW       = 3'd1,
    OP_UPD_QTY   = 3'd2,
    OP_UPD_PRICE = 3'd3,
    OP_CANCEL    = 3'd4
  } op_t;

  // What the back end has to do with a queued transaction
  typedef enum logic [2:0] {
    K_NEW    = 3'd0,
    K_CHANGE = 3'd1,
    K_ACK    = 3'd2,
    K_FILL   = 3'd3,
    K_REPLY  = 3'd4
  } kind_t;

  // Input payload, first field in the lowest bits
  localparam int IN_FIELDS_W = ID_BITS + 1 + PRICE_BITS + QTY_BITS + 1 + 3;
  localparam int IN_W        = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int IN_PAD      = IN_W - IN_FIELDS_W;

  typedef struct packed {
    logic [IN_PAD-1:0]     pad;
    logic [2:0]            ack_op;
    logic                  accepted;
    logic [QTY_BITS-1:0]   qty;
    logic [PRICE_BITS-1:0] price;
    logic                  side;
    logic [ID_BITS-1:0]    order_id;
  } in_t;

  // Result payload, first field in the lowest bits
  localparam int OUT_FIELDS_W = 1 + ID_BITS + 3 + 3 + QTY_BITS + QTY_BITS + PRICE_BITS + 3;
  localparam int OUT_W        = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD      = OUT_W - OUT_FIELDS_W;

  typedef struct packed {
    logic [OUT_PAD-1:0]    pad;
    logic                  stop_latched;
    logic                  overfill;
    logic                  out_side;
    logic [PRICE_BITS-1:0] out_price;
    logic [QTY_BITS-1:0]   out_filled;
    logic [QTY_BITS-1:0]   out_leave;
    op_t                   out_op;
    status_t               order_status;
    logic [ID_BITS-1:0]    assigned_id;
    logic                  out_ok;
  } res_t;

  // One order table entry as held in RAM
  typedef struct packed {
    status_t               status;
    op_t                   op;
    logic                  side;
    logic [PRICE_BITS-1:0] price;
    logic [QTY_BITS-1:0]   leave;
    logic [QTY_BITS-1:0]   filled;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Classified transaction travelling from front to back
  typedef struct packed {
    kind_t                 kind;
    logic                  ok;
    logic [ID_BITS-1:0]    id;
    logic                  side;
    logic [PRICE_BITS-1:0] price;
    logic [QTY_BITS-1:0]   qty;
    logic                  accepted;
    logic [2:0]            ack_op;
    logic                  stop;
  } qitem_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// File: src/olt_ram.sv
// ----------------------------------------------------------------------------
// olt_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module olt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/olt_front.sv
// ----------------------------------------------------------------------------
// olt_front
// Accepts events, allocates ids, tracks known ids and the stop flag.
// ----------------------------------------------------------------------------
module olt_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [olt_pkg::IN_W-1:0] s_tdata,
  input  logic [2:0]       s_tuser,
  input  olt_pkg::q_stat_t q_stat,
  output logic             q_push,
  output olt_pkg::qitem_t  q_item
);
  import olt_pkg::*;

  logic [CNT_BITS-1:0] next_id;
  logic [CNT_BITS-1:0] next_id_next;
  logic                stop_flag;
  logic                stop_flag_next;
  in_t                 din;
  logic                known;
  logic                table_full;

  assign din        = in_t'(s_tdata);
  assign s_tready   = !q_stat.full;
  assign q_push     = s_tvalid && s_tready;
  assign known      = {1'b0, din.order_id} < next_id;
  assign table_full = next_id == CNT_BITS'(MAX_ORDERS);

  always_comb begin
    next_id_next   = next_id;
    stop_flag_next = stop_flag;
    q_item          = '0;
    q_item.kind     = K_REPLY;
    q_item.side     = din.side;
    q_item.price    = din.price;
    q_item.qty      = din.qty;
    q_item.accepted = din.accepted;
    q_item.ack_op   = din.ack_op;
    unique case (cmd_t'(s_tuser))
      CMD_NEW: begin
        if (!table_full) begin
          q_item.kind  = K_NEW;
          q_item.ok    = 1'b1;
          q_item.id    = next_id[ID_BITS-1:0];
          next_id_next = next_id + 1'b1;
        end
      end
      CMD_CHANGE: begin
        q_item.id = din.order_id;
        if (known) begin
          q_item.kind = K_CHANGE;
          q_item.ok   = 1'b1;
        end
      end
      CMD_ACK, CMD_FILL: begin
        q_item.id = din.order_id;
        if (known) begin
          q_item.kind = (cmd_t'(s_tuser) == CMD_ACK) ? K_ACK : K_FILL;
          q_item.ok   = 1'b1;
        end else begin
          stop_flag_next = 1'b1;
        end
      end
      CMD_DISC: begin
        q_item.ok      = 1'b1;
        stop_flag_next = 1'b1;
      end
      default: begin
        q_item.ok = 1'b0;
      end
    endcase
    q_item.stop = stop_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_id   <= '0;
      stop_flag <= 1'b0;
    end else if (q_push) begin
      next_id   <= next_id_next;
      stop_flag <= stop_flag_next;
    end
  end

endmodule

// File: src/olt_queue.sv
// ----------------------------------------------------------------------------
// olt_queue
// Short FIFO of classified transactions between front and back.
// ----------------------------------------------------------------------------
module olt_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  olt_pkg::qitem_t  push_item,
  input  logic             pop,
  output olt_pkg::qitem_t  head,
  output olt_pkg::q_stat_t stat
);
  import olt_pkg::*;

  localparam int PTR_BITS = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W    = $clog2(QDEPTH + 1);

  qitem_t              slots [QDEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_W-1:0]    count;

  assign head       = slots[rd_ptr];
  assign stat.full  = count == CNT_W'(QDEPTH);
  assign stat.empty = count == '0;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: src/olt_back.sv
// ----------------------------------------------------------------------------
// olt_back
// Read-modify-write of one order entry per transaction, result register.
// ----------------------------------------------------------------------------
module olt_back (
  input  logic             clk,
  input  logic             rst,
  input  olt_pkg::q_stat_t q_stat,
  input  olt_pkg::qitem_t  q_head,
  output logic             q_pop,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [olt_pkg::OUT_W-1:0] m_tdata
);
  import olt_pkg::*;

  typedef enum logic [1:0] {
    B_IDLE = 2'b01,
    B_EXEC = 2'b10
  } bstate_t;

  bstate_t             state;
  qitem_t              work;
  logic [ENTRY_W-1:0]  rdata;
  entry_t              cur;
  entry_t              upd;
  res_t                res;
  res_t                res_next;
  logic                we;
  logic                load;
  status_t             live;
  logic [QTY_BITS:0]   fill_sum;
  logic                over;

  assign q_pop = (state == B_IDLE) && !q_stat.empty;
  assign load  = (state == B_EXEC) && (!m_tvalid || m_tready);
  assign cur   = entry_t'(rdata);

  olt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_ORDERS)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (work.id),
    .wdata (upd),
    .re    (q_pop),
    .raddr (q_head.id),
    .rdata (rdata)
  );

  always_comb begin
    upd      = cur;
    we       = 1'b0;
    live     = (cur.filled != '0) ? ST_PARTIAL : ST_ACKED;
    fill_sum = {1'b0, cur.filled} + {1'b0, work.qty};
    over     = work.qty > cur.leave;
    case (work.kind)
      K_NEW: begin
        upd.status = ST_SENDING;
        upd.op     = OP_NEW;
        upd.side   = work.side;
        upd.price  = work.price;
        upd.leave  = work.qty;
        upd.filled = '0;
        we         = load;
      end
      K_CHANGE: begin
        upd.leave  = work.qty;
        upd.status = ST_SENDING;
        if (work.price != '0) begin
          upd.price = work.price;
        end
        if (work.qty == '0) begin
          upd.op = OP_CANCEL;
        end else if (work.price != '0) begin
          upd.op = OP_UPD_PRICE;
        end else begin
          upd.op = OP_UPD_QTY;
        end
        we = load;
      end
      K_ACK: begin
        upd.op = OP_UNKNOWN;
        if (cur.status inside {ST_FILLED, ST_CANCELLED, ST_FAILED}) begin
          // late ack on a finished order: status kept
        end else if (work.accepted) begin
          if (work.ack_op == OP_NEW) begin
            if (cur.status == ST_SENDING) begin
              upd.status = ST_ACKED;
            end
          end else if (work.ack_op == OP_UPD_QTY || work.ack_op == OP_UPD_PRICE) begin
            upd.status = live;
          end else if (work.ack_op == OP_CANCEL) begin
            upd.status = ST_CANCELLED;
            upd.leave  = '0;
          end
        end else if (work.ack_op == OP_NEW) begin
          upd.status = ST_FAILED;
          upd.leave  = '0;
        end else begin
          upd.status = live;
        end
        we = load;
      end
      K_FILL: begin
        upd.op     = OP_UNKNOWN;
        upd.filled = fill_sum[QTY_BITS] ? '1 : fill_sum[QTY_BITS-1:0];
        upd.leave  = over ? '0 : cur.leave - work.qty;
        upd.status = (work.qty >= cur.leave) ? ST_FILLED : ST_PARTIAL;
        we         = load;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_comb begin
    res_next              = '0;
    res_next.out_ok       = work.ok;
    res_next.assigned_id  = work.id;
    res_next.stop_latched = work.stop;
    if (work.kind != K_REPLY) begin
      res_next.order_status = upd.status;
      res_next.out_op       = upd.op;
      res_next.out_leave    = upd.leave;
      res_next.out_filled   = upd.filled;
      res_next.out_price    = upd.price;
      res_next.out_side     = upd.side;
      res_next.overfill     = (work.kind == K_FILL) && over;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      work <= q_head;
    end
    if (load) begin
      res <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      unique case (state)
        B_IDLE: begin
          if (q_pop) begin
            state <= B_EXEC;
          end
        end
        B_EXEC: begin
          if (load) begin
            state <= B_IDLE;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign m_tdata = res;

endmodule

// File: src/order_lifecycle_tracker_top.sv
// ----------------------------------------------------------------------------
// order_lifecycle_tracker_top: input passes queue, table read, result register.
// Back end takes no new item before the last one's read-modify-write is done.
// Reset clears the id counter, stop flag, queue and result valid flag.
// ----------------------------------------------------------------------------
//
// Structure
//   olt_front : takes input transactions, decodes the command, allocates ids
//               for new orders, decides whether an id is known and keeps the
//               sticky stop flag. Everything the back end needs travels in
//               one classified queue item.
//   olt_queue : two-entry FIFO so that the front keeps accepting while the
//               back end or the downstream side stalls.
//   olt_back  : per item, reads the order entry (registered RAM read), works
//               out the new entry and result, writes back and loads the
//               output register. The write always lands before the next
//               read, so no forwarding is needed.
// The order table itself is not cleared at reset: only ids below the
// allocation counter are ever used, and those have all been written.
module order_lifecycle_tracker_top (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // order_id[7:0], side[8], price[40:9], qty[72:41], accepted[73], ack_op[76:74]
  input  logic [olt_pkg::IN_W-1:0]  s_tdata,
  // cmd[2:0]
  input  logic [2:0]                s_tuser,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // out_ok[0], assigned_id[8:1], order_status[11:9], out_op[14:12],
  // out_leave[46:15], out_filled[78:47], out_price[110:79], out_side[111],
  // overfill[112], stop_latched[113]
  output logic [olt_pkg::OUT_W-1:0] m_tdata
);
  import olt_pkg::*;

  q_stat_t q_stat;
  logic    q_push;
  logic    q_pop;
  qitem_t  q_in;
  qitem_t  q_head;

  olt_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_item   (q_in)
  );

  olt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  olt_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_stat   (q_stat),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Checks on the queue handover between front and back
`include "order_lifecycle_tracker_top_assert.svh"

  `OLT_ASSERT_NOW(a_push_not_full, clk, rst, q_push, !q_stat.full, "push into full queue")
  `OLT_ASSERT_NOW(a_pop_not_empty, clk, rst, q_pop, !q_stat.empty, "pop from empty queue")
  `OLT_ASSERT_NEXT(a_pop_spacing, clk, rst, q_pop, !q_pop, "back end popped twice in a row")

endmodule
